/* design/uer_pkg.sv */
// Shared types and constants of the ultrasonic echo ranger.
// Used by every module of the block and by its checker; depends on nothing.
package uer_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;
   localparam int LIMIT_BITS     = 24;
   localparam int SMALL_BITS     = 8;
   localparam int DIST_OUT_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_CM          = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICKS_PER_CM       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ECHO_WAIT_LIMIT    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ECHO_LENGTH_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIGGER_LOW_TICKS  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIGGER_HIGH_TICKS = 3'd5;

   localparam logic [SMALL_BITS-1:0] RST_OFFSET_CM          = 8'd13;
   localparam logic [SMALL_BITS-1:0] RST_TICKS_PER_CM       = 8'd58;
   localparam logic [LIMIT_BITS-1:0] RST_ECHO_WAIT_LIMIT    = 24'd1000000;
   localparam logic [LIMIT_BITS-1:0] RST_ECHO_LENGTH_LIMIT  = 24'd1000000;
   localparam logic [SMALL_BITS-1:0] RST_TRIGGER_LOW_TICKS  = 8'd2;
   localparam logic [SMALL_BITS-1:0] RST_TRIGGER_HIGH_TICKS = 8'd10;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TLOW,
      PH_THIGH,
      PH_WAIT,
      PH_PULSE
   } phase_type;

   typedef struct packed {
      logic start_req;
      logic echo_level;
   } req_type;

   typedef struct packed {
      logic                     trigger_level;
      logic                     pin_driven;
      logic                     busy_res;
      logic                     distance_valid;
      logic [DIST_OUT_BITS-1:0] distance_cm;
      logic                     finished_event;
      logic                     stopped;
   } rsp_type;

   typedef struct packed {
      logic [SMALL_BITS-1:0] offset_cm;
      logic [SMALL_BITS-1:0] ticks_per_cm;
      logic [LIMIT_BITS-1:0] echo_wait_limit;
      logic [LIMIT_BITS-1:0] echo_length_limit;
      logic [SMALL_BITS-1:0] trigger_low_ticks;
      logic [SMALL_BITS-1:0] trigger_high_ticks;
   } cfg_type;

endpackage

/* design/uer_csr.sv */
// Configuration register file of the ultrasonic echo ranger.
// Depends on uer_pkg for the register indexes, reset values and cfg_type.
module uer_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [uer_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output uer_pkg::cfg_type                    cfg
);

   uer_pkg::cfg_type cfg_ff;
   uer_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            uer_pkg::CSR_OFFSET_CM: begin
               cfg_in.offset_cm = csr_wdata[uer_pkg::SMALL_BITS-1:0];
            end
            uer_pkg::CSR_TICKS_PER_CM: begin
               cfg_in.ticks_per_cm = csr_wdata[uer_pkg::SMALL_BITS-1:0];
            end
            uer_pkg::CSR_ECHO_WAIT_LIMIT: begin
               cfg_in.echo_wait_limit = csr_wdata[uer_pkg::LIMIT_BITS-1:0];
            end
            uer_pkg::CSR_ECHO_LENGTH_LIMIT: begin
               cfg_in.echo_length_limit = csr_wdata[uer_pkg::LIMIT_BITS-1:0];
            end
            uer_pkg::CSR_TRIGGER_LOW_TICKS: begin
               cfg_in.trigger_low_ticks = csr_wdata[uer_pkg::SMALL_BITS-1:0];
            end
            uer_pkg::CSR_TRIGGER_HIGH_TICKS: begin
               cfg_in.trigger_high_ticks = csr_wdata[uer_pkg::SMALL_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_cm          <= uer_pkg::RST_OFFSET_CM;
         cfg_ff.ticks_per_cm       <= uer_pkg::RST_TICKS_PER_CM;
         cfg_ff.echo_wait_limit    <= uer_pkg::RST_ECHO_WAIT_LIMIT;
         cfg_ff.echo_length_limit  <= uer_pkg::RST_ECHO_LENGTH_LIMIT;
         cfg_ff.trigger_low_ticks  <= uer_pkg::RST_TRIGGER_LOW_TICKS;
         cfg_ff.trigger_high_ticks <= uer_pkg::RST_TRIGGER_HIGH_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/uer_core.sv */
// Measurement sequencer of the ultrasonic echo ranger: phase state machine,
// tick and centimetre counters, and the result of each transfer.
// Depends on uer_pkg for phase_type, req_type, rsp_type and cfg_type.
module uer_core #(
   parameter int TIMER_BITS    = 24,
   parameter int DISTANCE_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  uer_pkg::req_type req,
   input  uer_pkg::cfg_type cfg,
   output uer_pkg::rsp_type rsp
);

   localparam int CMP_BITS =
      (TIMER_BITS > uer_pkg::LIMIT_BITS) ? TIMER_BITS : uer_pkg::LIMIT_BITS;
   localparam int WIDE_BITS =
      (DISTANCE_BITS > uer_pkg::DIST_OUT_BITS) ? DISTANCE_BITS : uer_pkg::DIST_OUT_BITS;
   localparam int SB = uer_pkg::SMALL_BITS;

   uer_pkg::phase_type         phase_ff, phase_in;
   logic [TIMER_BITS-1:0]      ticks_ff, ticks_in;
   logic [SB-1:0]              sub_ff, sub_in;
   logic [DISTANCE_BITS-1:0]   cm_ff, cm_in;
   logic [DISTANCE_BITS-1:0]   last_ff, last_in;
   logic                       stop_ff, stop_in;

   logic [TIMER_BITS-1:0]      ticks_inc;
   logic [TIMER_BITS-1:0]      base_ticks, ht_ticks;
   logic [SB-1:0]              base_sub, ht_sub_raw, ht_sub;
   logic [DISTANCE_BITS-1:0]   base_cm, ht_cm;
   logic                       ht_wrap;
   logic                       length_timeout;
   logic                       wait_timeout;
   logic [DISTANCE_BITS:0]     dist_sum;
   logic [DISTANCE_BITS-1:0]   dist_sat;
   logic [WIDE_BITS-1:0]       last_wide;
   logic                       valid;
   logic                       finished;

   always_comb begin
      ticks_inc = (&ticks_ff) ? ticks_ff : ticks_ff + TIMER_BITS'(1);

      base_ticks = (phase_ff == uer_pkg::PH_WAIT) ? '0 : ticks_ff;
      base_sub   = (phase_ff == uer_pkg::PH_WAIT) ? '0 : sub_ff;
      base_cm    = (phase_ff == uer_pkg::PH_WAIT) ? '0 : cm_ff;
      ht_ticks   = (&base_ticks) ? base_ticks : base_ticks + TIMER_BITS'(1);
      ht_sub_raw = base_sub + SB'(1);
      ht_wrap    = ht_sub_raw >= cfg.ticks_per_cm;
      ht_sub     = ht_wrap ? '0 : ht_sub_raw;
      ht_cm      = (ht_wrap && !(&base_cm)) ? base_cm + DISTANCE_BITS'(1) : base_cm;

      length_timeout = CMP_BITS'(ht_ticks) > CMP_BITS'(cfg.echo_length_limit);
      wait_timeout   = CMP_BITS'(ticks_inc) > CMP_BITS'(cfg.echo_wait_limit);

      dist_sum = (DISTANCE_BITS+1)'(cfg.offset_cm) + (DISTANCE_BITS+1)'(cm_ff);
      dist_sat = dist_sum[DISTANCE_BITS] ? '1 : dist_sum[DISTANCE_BITS-1:0];

      phase_in = phase_ff;
      ticks_in = ticks_ff;
      sub_in   = sub_ff;
      cm_in    = cm_ff;
      last_in  = last_ff;
      stop_in  = stop_ff;
      valid    = 1'b0;
      finished = 1'b0;

      unique case (phase_ff)
         uer_pkg::PH_IDLE: begin
            if (req.start_req) begin
               if (cfg.trigger_low_ticks != '0) begin
                  phase_in = uer_pkg::PH_TLOW;
                  ticks_in = TIMER_BITS'(1);
               end else if (cfg.trigger_high_ticks != '0) begin
                  phase_in = uer_pkg::PH_THIGH;
                  ticks_in = TIMER_BITS'(1);
               end else begin
                  phase_in = uer_pkg::PH_WAIT;
                  ticks_in = '0;
               end
            end
         end
         uer_pkg::PH_TLOW: begin
            if (ticks_ff >= TIMER_BITS'(cfg.trigger_low_ticks)) begin
               if (cfg.trigger_high_ticks != '0) begin
                  phase_in = uer_pkg::PH_THIGH;
                  ticks_in = TIMER_BITS'(1);
               end else begin
                  phase_in = uer_pkg::PH_WAIT;
                  ticks_in = '0;
               end
            end else begin
               ticks_in = ticks_inc;
            end
         end
         uer_pkg::PH_THIGH: begin
            if (ticks_ff >= TIMER_BITS'(cfg.trigger_high_ticks)) begin
               phase_in = uer_pkg::PH_WAIT;
               ticks_in = '0;
            end else begin
               ticks_in = ticks_inc;
            end
         end
         uer_pkg::PH_WAIT: begin
            if (req.echo_level) begin
               if (stop_ff) begin
                  phase_in = uer_pkg::PH_IDLE;
                  ticks_in = '0;
               end else begin
                  sub_in = ht_sub;
                  cm_in  = ht_cm;
                  if (length_timeout) begin
                     stop_in  = 1'b1;
                     finished = 1'b1;
                     phase_in = uer_pkg::PH_IDLE;
                     ticks_in = '0;
                  end else begin
                     phase_in = uer_pkg::PH_PULSE;
                     ticks_in = ht_ticks;
                  end
               end
            end else if (wait_timeout) begin
               stop_in  = 1'b1;
               finished = 1'b1;
               phase_in = uer_pkg::PH_IDLE;
               ticks_in = '0;
            end else begin
               ticks_in = ticks_inc;
            end
         end
         uer_pkg::PH_PULSE: begin
            if (req.echo_level) begin
               sub_in = ht_sub;
               cm_in  = ht_cm;
               if (length_timeout) begin
                  stop_in  = 1'b1;
                  finished = 1'b1;
                  phase_in = uer_pkg::PH_IDLE;
                  ticks_in = '0;
               end else begin
                  ticks_in = ht_ticks;
               end
            end else begin
               last_in  = dist_sat;
               valid    = 1'b1;
               phase_in = uer_pkg::PH_IDLE;
               ticks_in = '0;
            end
         end
         default: begin
            phase_in = uer_pkg::PH_IDLE;
            ticks_in = '0;
         end
      endcase

      last_wide = WIDE_BITS'(last_in);
      rsp.trigger_level  = phase_in == uer_pkg::PH_THIGH;
      rsp.pin_driven     = (phase_in == uer_pkg::PH_TLOW) || (phase_in == uer_pkg::PH_THIGH);
      rsp.busy_res       = phase_in != uer_pkg::PH_IDLE;
      rsp.distance_valid = valid;
      rsp.distance_cm    = (last_wide > WIDE_BITS'({uer_pkg::DIST_OUT_BITS{1'b1}}))
                           ? '1 : last_wide[uer_pkg::DIST_OUT_BITS-1:0];
      rsp.finished_event = finished;
      rsp.stopped        = stop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uer_pkg::PH_IDLE;
         ticks_ff <= '0;
         sub_ff   <= '0;
         cm_ff    <= '0;
         last_ff  <= '0;
         stop_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         sub_ff   <= sub_in;
         cm_ff    <= cm_in;
         last_ff  <= last_in;
         stop_ff  <= stop_in;
      end
   end

endmodule

/* design/uer_out_buf.sv */
// Result register with one skid entry for the ultrasonic echo ranger.
// Depends on uer_pkg for rsp_type.
module uer_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  uer_pkg::rsp_type in_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output uer_pkg::rsp_type rsp_data
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   uer_pkg::rsp_type out_ff, out_in;
   uer_pkg::rsp_type skid_ff, skid_in;
   logic             take;

   assign in_ready = !skid_valid_ff;
   assign take     = in_valid && in_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && rsp_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (take) begin
            out_in = in_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (!out_valid_ff) begin
         if (take) begin
            out_in       = in_data;
            out_valid_in = 1'b1;
         end
      end else if (take) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* design/ultrasonic_echo_ranger.sv */
// Top level of the ultrasonic echo ranger: configuration registers,
// measurement sequencer and result buffer. Depends on uer_pkg and the uer_ modules.
//
// Each transfer on the req_ channel is one microsecond sample: a start request
// and the sampled echo pin level. Every transfer yields exactly one result on
// the rsp_ channel, describing the pin drive, busy state, distance and stop
// flag after that tick.
// A result is registered in the output register, or in the skid entry when the
// receiver stalls. The block takes one transfer per cycle while req_ready is high;
// the sequencer steps on each transfer, so the rate is set by the handshake alone.
// When the receiver stalls, one more transfer is taken into the skid entry,
// after which req_ready drops until the output register drains.
// Reset clears the sequencer to idle, the counters, the last distance and the
// stop flag, loads the configuration registers with their defaults and
// empties the result buffer. Configuration writes on the csr_ port take effect
// at the clock edge at which csr_write_en is high; write only while idle.
module ultrasonic_echo_ranger #(
   parameter int TIMER_BITS    = 24,
   parameter int DISTANCE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  uer_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output uer_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write_en,
   input  logic [uer_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   uer_pkg::cfg_type cfg;
   uer_pkg::rsp_type core_rsp;
   logic             step;

   assign step = req_valid && req_ready;

   uer_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   uer_core #(
      .TIMER_BITS    (TIMER_BITS),
      .DISTANCE_BITS (DISTANCE_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_data),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   uer_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (core_rsp),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* design/uer_checker.sv */
// Port-level assertions for the ultrasonic echo ranger and the bind that
// attaches them to the top level. Depends on uer_pkg for rsp_type.
module uer_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input uer_pkg::rsp_type rsp_data
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result changed before its transfer.");

   a_trigger_driven: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.trigger_level |-> rsp_data.pin_driven && rsp_data.busy_res)
      else $error("Trigger high without a driven pin in a busy sequence.");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.distance_valid || rsp_data.finished_event)
         |-> !rsp_data.busy_res && !(rsp_data.distance_valid && rsp_data.finished_event))
      else $error("Sequence end reported while still busy or twice.");

   a_timeout_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.finished_event |-> rsp_data.stopped)
      else $error("Timeout reported without the stop flag.");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
